### src/itoa_pkg.sv
// Shared types, constants and the digit-to-character function of the integer-to-text block.
`default_nettype none
package itoa_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int RADIX_WIDTH         = 6;
  localparam int CHAR_WIDTH          = 7;

  localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_WIDTH-1:0] RADIX_DEC   = 6'd10;

  localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS  = 7'h2D;
  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO   = 7'h30;
  localparam logic [CHAR_WIDTH-1:0] ASCII_ALPHA  = 7'h37;  // 'A' less ten
  localparam logic [CHAR_WIDTH-1:0] ASCII_Z      = 7'h5A;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_SIGN,
    ST_READ,
    ST_PUT
  } state_t;

  // Digits 0-9 map to '0'-'9', 10-35 to 'A'-'Z'; anything larger saturates to 'Z'.
  function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] c;
    if (d < 6'd10) begin
      c = ASCII_ZERO + {1'b0, d};
    end else if (d < RADIX_MAX) begin
      c = ASCII_ALPHA + {1'b0, d};
    end else begin
      c = ASCII_Z;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### src/itoa_if.sv
// Valid/ready channel interfaces for the integer input and the character output.
`default_nettype none
interface itoa_value_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itoa_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;
  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

### src/itoa_div.sv
// Restoring divider by a small radix, one quotient bit per cycle.
`default_nettype none
module itoa_div
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [RADIX_WIDTH-1:0] divisor,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      quotient,
  output logic [RADIX_WIDTH-1:0]      remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH-1:0] dvd;
  logic [RADIX_WIDTH-1:0] rem;
  logic [RADIX_WIDTH:0]   trial;
  logic [RADIX_WIDTH:0]   diff;
  logic                   take;

  // The partial remainder stays below the divisor, so six bits hold it.
  assign trial = {rem, dvd[VALUE_WIDTH-1]};
  assign take  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[VALUE_WIDTH-2:0], take};
      rem <= take ? diff[RADIX_WIDTH-1:0] : trial[RADIX_WIDTH-1:0];
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule
`default_nettype wire

### src/integer_to_ascii_radix.sv
// Top level: converts an integer to ASCII text in a configurable radix (signed in radix ten only).
//
//   Channel   Role    Payload                 Transaction
//   number    sink    value [VALUE_WIDTH]     one integer to convert
//   text      source  character [7], last     one ASCII character
//   cfg       write   cfg_data [6]            radix register, written when cfg_write is high
//
// Each digit costs one pass of the shared divider; after the last division the block
// emits a minus sign if the number is negative, then one character per digit, and
// returns to idle to take the next number.
// The worst case at 32 bits is radix two, with 32 digits.
// Reset is synchronous and active high; it sets the radix to ten and clears the
// sequencer and the output valid. A stall on text simply holds the sequencer in the
// emit step; number is ready only when the sequencer is idle.
`default_nettype none
module integer_to_ascii_radix
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [RADIX_WIDTH-1:0] cfg_data,
  itoa_value_if.sink                  number,
  itoa_char_if.source                 text
);

  localparam int IDX_W = $clog2(VALUE_WIDTH);
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  state_t state, state_next;

  logic [RADIX_WIDTH-1:0] radix;
  logic [RADIX_WIDTH-1:0] base;
  logic [RADIX_WIDTH-1:0] base_sat;
  logic                   negative_flag;
  logic [VALUE_WIDTH-1:0] remaining_quotient;
  logic [CNT_W-1:0]       digit_count;
  logic [CNT_W-1:0]       count_inc;
  logic [CNT_W-1:0]       count_dec;

  logic [RADIX_WIDTH-1:0] digit_store [VALUE_WIDTH];
  logic [RADIX_WIDTH-1:0] rd_digit;

  logic                   accept;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [RADIX_WIDTH-1:0] div_rem;
  logic                   out_free;
  logic                   load_sign;
  logic                   load_digit;

  logic                   text_valid;
  logic [CHAR_WIDTH-1:0]  text_char;
  logic                   text_last;

  // Radix register; values outside two to thirty-six saturate at the ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_write) begin
      radix <= cfg_data;
    end
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      base_sat = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base_sat = RADIX_MAX;
    end else begin
      base_sat = radix;
    end
  end

  assign accept    = number.valid && number.ready;
  assign count_inc = digit_count + 1'b1;
  assign count_dec = digit_count - 1'b1;
  assign out_free  = !text_valid || text.ready;

  itoa_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (remaining_quotient),
    .divisor   (base),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: divide repeatedly, storing digits least significant first, then emit
  // any minus sign and read the digits back from the top of the store.
  always_comb begin
    state_next   = state;
    number.ready = 1'b0;
    div_start    = 1'b0;
    load_sign    = 1'b0;
    load_digit   = 1'b0;
    case (state)
      ST_IDLE: begin
        number.ready = 1'b1;
        if (number.valid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (div_quot != '0 && count_inc < CNT_W'(VALUE_WIDTH)) begin
            state_next = ST_START;
          end else if (negative_flag) begin
            state_next = ST_SIGN;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          load_sign  = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) begin
          load_digit = 1'b1;
          state_next = (digit_count == CNT_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Working registers of the conversion.
  always_ff @(posedge clk) begin
    if (rst) begin
      negative_flag      <= 1'b0;
      remaining_quotient <= '0;
      digit_count        <= '0;
      base               <= RADIX_DEC;
    end else begin
      if (accept) begin
        base          <= base_sat;
        negative_flag <= (base_sat == RADIX_DEC) && number.value[VALUE_WIDTH-1];
        // The most negative value negates to itself, which read unsigned is its magnitude.
        if ((base_sat == RADIX_DEC) && number.value[VALUE_WIDTH-1]) begin
          remaining_quotient <= ~number.value + 1'b1;
        end else begin
          remaining_quotient <= number.value;
        end
        digit_count <= '0;
      end else if (state == ST_WAIT && div_done) begin
        remaining_quotient <= div_quot;
        digit_count        <= count_inc;
      end else if (load_digit) begin
        digit_count <= count_dec;
      end
    end
  end

  // Digit store, least significant digit at index zero.
  always_ff @(posedge clk) begin
    if (state == ST_WAIT && div_done) begin
      digit_store[digit_count[IDX_W-1:0]] <= div_rem;
    end
    rd_digit <= digit_store[count_dec[IDX_W-1:0]];
  end

  // Output register; it holds a character until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (load_sign || load_digit) begin
      text_valid <= 1'b1;
    end else if (text.ready) begin
      text_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sign) begin
      text_char <= ASCII_MINUS;
      text_last <= 1'b0;
    end else if (load_digit) begin
      text_char <= digit_char(rd_digit);
      text_last <= (digit_count == CNT_W'(1));
    end
  end

  assign text.valid     = text_valid;
  assign text.character = text_char;
  assign text.last      = text_last;

endmodule
`default_nettype wire
